/* rtl/fbl_pkg.sv */
// shared types and constants for the framed table bilinear lookup
package fbl_pkg;

	localparam int OP_BITS       = 2;
	localparam int IDX_BITS      = 14;
	localparam int SAMPLE_BITS   = 16;
	localparam int POS_BITS      = 17;
	localparam int FRAC_BITS     = 16;
	localparam int WCFG_BITS     = 11;
	localparam int HCFG_BITS     = 5;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 11;

	localparam int DEF_MAX_WIDTH  = 1024;
	localparam int DEF_MAX_FRAMES = 16;

	localparam logic [WCFG_BITS-1:0] WIDTH_RESET  = WCFG_BITS'(1024);
	localparam logic [HCFG_BITS-1:0] FRAMES_RESET = HCFG_BITS'(1);

	typedef enum logic [OP_BITS-1:0] {
		OP_WRITE = 2'd0,
		OP_LERP1 = 2'd1,
		OP_LERP2 = 2'd2,
		OP_NONE  = 2'd3
	} op_t;

	typedef enum logic [CFG_IDX_BITS-1:0] {
		REG_WIDTH  = 1'd0,
		REG_FRAMES = 1'd1
	} cfg_reg_t;

	// step enables from the controller to the datapath
	typedef struct packed {
		logic       accept;
		logic       mul_pos;
		logic       sel;
		logic       base;
		logic       rd_en;
		logic [1:0] rd_slot;
		logic       cap_en;
		logic [1:0] cap_slot;
		logic       mul_x;
		logic       sum_x;
		logic       mul_y;
		logic       load_out;
	} fbl_cmd_t;

endpackage

/* rtl/framed_table_bilinear_lookup.sv */
// Framed sample table with linear and bilinear lookup at Q16 positions. The block works on
// one word at a time: before the next word is taken, a lookup runs the four reads of the
// single-port sample memory plus the position, address and two interpolation multiply steps
// run by the controller; a write or unused op goes straight to the finish state. Writes land
// in the memory at the edge the word is accepted. A finished result sits in the output
// register, so a new word is accepted while it waits to be taken. The sample memory has no
// reset and no clearing pass; entries read before being written give undefined results.
// Configuration may be written only while the block is idle.
module framed_table_bilinear_lookup #(
	parameter int MAX_WIDTH  = fbl_pkg::DEF_MAX_WIDTH,
	parameter int MAX_FRAMES = fbl_pkg::DEF_MAX_FRAMES
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    cfg_we,
	input  logic [fbl_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [fbl_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	input  logic                                    in_valid,
	output logic                                    in_ready,
	input  logic [fbl_pkg::OP_BITS-1:0]             op,
	input  logic [fbl_pkg::IDX_BITS-1:0]            entry_index,
	input  logic signed [fbl_pkg::SAMPLE_BITS-1:0]  entry_value,
	input  logic [fbl_pkg::POS_BITS-1:0]            x_pos,
	input  logic [fbl_pkg::POS_BITS-1:0]            y_pos,
	output logic                                    out_valid,
	input  logic                                    out_ready,
	output logic signed [fbl_pkg::SAMPLE_BITS-1:0]  value
);
	import fbl_pkg::*;

	fbl_cmd_t cmd;

	fbl_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.op        (op),
		.in_ready  (in_ready),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.cmd       (cmd)
	);

	fbl_dpath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_FRAMES (MAX_FRAMES)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.op          (op),
		.entry_index (entry_index),
		.entry_value (entry_value),
		.x_pos       (x_pos),
		.y_pos       (y_pos),
		.value       (value)
	);

endmodule

/* rtl/fbl_ctrl.sv */
// controller state machine sequencing one word at a time through the datapath
module fbl_ctrl (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	input  logic [fbl_pkg::OP_BITS-1:0]    op,
	output logic                           in_ready,
	input  logic                           out_ready,
	output logic                           out_valid,
	output fbl_pkg::fbl_cmd_t              cmd
);
	import fbl_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_POS,
		ST_SEL,
		ST_BASE,
		ST_RD0,
		ST_RD1,
		ST_RD2,
		ST_RD3,
		ST_MUL_X,
		ST_SUM_X,
		ST_MUL_Y,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;
	logic   is_lookup;

	assign is_lookup = (op == OP_LERP1) || (op == OP_LERP2);
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_nxt  = is_lookup ? ST_MUL_POS : ST_FINISH;
				end
			end
			ST_MUL_POS: begin
				cmd.mul_pos = 1'b1;
				state_nxt   = ST_SEL;
			end
			ST_SEL: begin
				cmd.sel   = 1'b1;
				state_nxt = ST_BASE;
			end
			ST_BASE: begin
				cmd.base  = 1'b1;
				state_nxt = ST_RD0;
			end
			ST_RD0: begin
				cmd.rd_en   = 1'b1;
				cmd.rd_slot = 2'd0;
				state_nxt   = ST_RD1;
			end
			ST_RD1: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_slot  = 2'd1;
				cmd.cap_en   = 1'b1;
				cmd.cap_slot = 2'd0;
				state_nxt    = ST_RD2;
			end
			ST_RD2: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_slot  = 2'd2;
				cmd.cap_en   = 1'b1;
				cmd.cap_slot = 2'd1;
				state_nxt    = ST_RD3;
			end
			ST_RD3: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_slot  = 2'd3;
				cmd.cap_en   = 1'b1;
				cmd.cap_slot = 2'd2;
				state_nxt    = ST_MUL_X;
			end
			ST_MUL_X: begin
				// last sample is taken straight from the read register
				cmd.mul_x = 1'b1;
				state_nxt = ST_SUM_X;
			end
			ST_SUM_X: begin
				cmd.sum_x = 1'b1;
				state_nxt = ST_MUL_Y;
			end
			ST_MUL_Y: begin
				cmd.mul_y = 1'b1;
				state_nxt = ST_FINISH;
			end
			ST_FINISH: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

/* rtl/fbl_dpath.sv */
// datapath: sample memory, configuration registers and interpolation arithmetic
module fbl_dpath #(
	parameter int MAX_WIDTH  = fbl_pkg::DEF_MAX_WIDTH,
	parameter int MAX_FRAMES = fbl_pkg::DEF_MAX_FRAMES
) (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  fbl_pkg::fbl_cmd_t                       cmd,
	input  logic                                    cfg_we,
	input  logic [fbl_pkg::CFG_IDX_BITS-1:0]        cfg_index,
	input  logic [fbl_pkg::CFG_DATA_BITS-1:0]       cfg_data,
	input  logic [fbl_pkg::OP_BITS-1:0]             op,
	input  logic [fbl_pkg::IDX_BITS-1:0]            entry_index,
	input  logic signed [fbl_pkg::SAMPLE_BITS-1:0]  entry_value,
	input  logic [fbl_pkg::POS_BITS-1:0]            x_pos,
	input  logic [fbl_pkg::POS_BITS-1:0]            y_pos,
	output logic signed [fbl_pkg::SAMPLE_BITS-1:0]  value
);
	import fbl_pkg::*;

	localparam int WB    = $clog2(MAX_WIDTH + 1);
	localparam int CB    = $clog2(MAX_WIDTH);
	localparam int HB    = $clog2(MAX_FRAMES + 1);
	localparam int FB    = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
	localparam int DEPTH = MAX_WIDTH * MAX_FRAMES;
	localparam int AW    = $clog2(DEPTH);
	localparam int PXW   = FRAC_BITS + WB;
	localparam int PYW   = POS_BITS + HB;
	localparam int WCW   = (WB > WCFG_BITS) ? WB : WCFG_BITS;
	localparam int HCW   = (HB > HCFG_BITS) ? HB : HCFG_BITS;
	localparam int IW    = ((AW > IDX_BITS) ? AW : IDX_BITS) + 1;
	localparam int SB    = SAMPLE_BITS;
	localparam int DW    = SB + 1;
	localparam int PW    = 2 * DW;

	// configuration
	logic [WCFG_BITS-1:0] width_cfg_q;
	logic [HCFG_BITS-1:0] frames_cfg_q;
	logic [WCW-1:0]       wcfg_wide;
	logic [HCW-1:0]       hcfg_wide;
	logic [WB-1:0]        w_eff;
	logic [HB-1:0]        h_eff;

	// item registers
	logic [OP_BITS-1:0]   op_q;
	logic [POS_BITS-1:0]  x_q;
	logic [POS_BITS-1:0]  y_q;
	logic [WB-1:0]        w_q;
	logic [HB-1:0]        h_q;

	logic [WB-1:0]        wm1;
	logic [HB-1:0]        hm1;
	logic [PXW-1:0]       posx_s1;
	logic [PYW-1:0]       posy_s1;

	logic [WB-1:0]        xlow;
	logic [HB:0]          ylow;
	logic                 x_first;
	logic                 x_last;
	logic                 y_last;
	logic [CB-1:0]        c0_s2;
	logic [CB-1:0]        c1_s2;
	logic [FRAC_BITS-1:0] fx_s2;
	logic [FB-1:0]        fr0_s2;
	logic [FB-1:0]        fr1_s2;
	logic [FRAC_BITS-1:0] fy_s2;

	logic [AW-1:0]        base0_s3;
	logic [AW-1:0]        base1_s3;

	// sample memory, single port
	logic [SB-1:0]        mem [DEPTH];
	logic [AW-1:0]        rd_addr;
	logic [AW-1:0]        mem_addr;
	logic                 mem_we;
	logic [SB-1:0]        rd_q;

	logic [SB-1:0]        a0_q;
	logic [SB-1:0]        b0_q;
	logic [SB-1:0]        a1_q;

	logic signed [DW-1:0] diff0;
	logic signed [DW-1:0] diff1;
	logic signed [DW-1:0] diffy;
	logic signed [DW-1:0] fxs;
	logic signed [DW-1:0] fys;
	logic signed [PW-1:0] prod0_s4;
	logic signed [PW-1:0] prod1_s4;
	logic [SB-1:0]        f0_s5;
	logic [SB-1:0]        f1_s5;
	logic signed [PW-1:0] prody_s6;
	logic                 is_lookup;
	logic [SB-1:0]        value_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_cfg_q  <= WIDTH_RESET;
			frames_cfg_q <= FRAMES_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_WIDTH:  width_cfg_q  <= cfg_data[WCFG_BITS-1:0];
				REG_FRAMES: frames_cfg_q <= cfg_data[HCFG_BITS-1:0];
				default: ;
			endcase
		end
	end

	// saturate the registers into their usable range
	assign wcfg_wide = WCW'(width_cfg_q);
	assign hcfg_wide = HCW'(frames_cfg_q);

	always_comb begin
		if (wcfg_wide == '0) begin
			w_eff = WB'(1);
		end else if (wcfg_wide > WCW'(MAX_WIDTH)) begin
			w_eff = WB'(MAX_WIDTH);
		end else begin
			w_eff = WB'(wcfg_wide);
		end
		if (hcfg_wide == '0) begin
			h_eff = HB'(1);
		end else if (hcfg_wide > HCW'(MAX_FRAMES)) begin
			h_eff = HB'(MAX_FRAMES);
		end else begin
			h_eff = HB'(hcfg_wide);
		end
	end

	assign wm1 = w_q - WB'(1);
	assign hm1 = h_q - HB'(1);

	// column and frame selection, edges collapse to one sample with zero fraction
	assign xlow    = posx_s1[PXW-1:FRAC_BITS];
	assign ylow    = posy_s1[PYW-1:FRAC_BITS];
	assign x_first = (w_q == WB'(1)) || (x_q == '0);
	assign x_last  = x_q[POS_BITS-1];
	assign y_last  = (ylow >= {1'b0, hm1});

	assign mem_we   = cmd.accept && (op == OP_WRITE) && (IW'(entry_index) < IW'(DEPTH));
	assign rd_addr  = (cmd.rd_slot[1] ? base1_s3 : base0_s3)
		+ AW'(cmd.rd_slot[0] ? c1_s2 : c0_s2);
	assign mem_addr = cmd.accept ? AW'(entry_index) : rd_addr;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= entry_value;
		end
		if (cmd.rd_en) begin
			rd_q <= mem[mem_addr];
		end
	end

	assign diff0 = $signed({b0_q[SB-1], b0_q}) - $signed({a0_q[SB-1], a0_q});
	assign diff1 = $signed({rd_q[SB-1], rd_q}) - $signed({a1_q[SB-1], a1_q});
	assign diffy = $signed({f1_s5[SB-1], f1_s5}) - $signed({f0_s5[SB-1], f0_s5});
	assign fxs   = $signed({1'b0, fx_s2});
	assign fys   = $signed({1'b0, fy_s2});

	assign is_lookup = (op_q == OP_LERP1) || (op_q == OP_LERP2);

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			op_q <= op;
			x_q  <= x_pos;
			y_q  <= y_pos;
			w_q  <= w_eff;
			h_q  <= h_eff;
		end
		if (cmd.mul_pos) begin
			posx_s1 <= PXW'(x_q[FRAC_BITS-1:0]) * PXW'(wm1);
			posy_s1 <= PYW'(y_q) * PYW'(hm1);
		end
		if (cmd.sel) begin
			if (x_first) begin
				c0_s2 <= '0;
				c1_s2 <= '0;
				fx_s2 <= '0;
			end else if (x_last) begin
				c0_s2 <= CB'(wm1);
				c1_s2 <= CB'(wm1);
				fx_s2 <= '0;
			end else begin
				c0_s2 <= CB'(xlow);
				c1_s2 <= CB'(xlow + WB'(1));
				fx_s2 <= posx_s1[FRAC_BITS-1:0];
			end
			if (op_q == OP_LERP1) begin
				fr0_s2 <= '0;
				fr1_s2 <= '0;
				fy_s2  <= '0;
			end else if (y_last) begin
				// at or past the last frame only that frame is used
				fr0_s2 <= FB'(hm1);
				fr1_s2 <= FB'(hm1);
				fy_s2  <= '0;
			end else begin
				fr0_s2 <= FB'(ylow);
				fr1_s2 <= FB'(ylow + 1'b1);
				fy_s2  <= posy_s1[FRAC_BITS-1:0];
			end
		end
		if (cmd.base) begin
			base0_s3 <= AW'(fr0_s2) * AW'(w_q);
			base1_s3 <= AW'(fr1_s2) * AW'(w_q);
		end
		if (cmd.cap_en) begin
			case (cmd.cap_slot)
				2'd0:    a0_q <= rd_q;
				2'd1:    b0_q <= rd_q;
				default: a1_q <= rd_q;
			endcase
		end
		if (cmd.mul_x) begin
			prod0_s4 <= diff0 * fxs;
			prod1_s4 <= diff1 * fxs;
		end
		if (cmd.sum_x) begin
			f0_s5 <= a0_q + prod0_s4[SB+FRAC_BITS-1:FRAC_BITS];
			f1_s5 <= a1_q + prod1_s4[SB+FRAC_BITS-1:FRAC_BITS];
		end
		if (cmd.mul_y) begin
			prody_s6 <= diffy * fys;
		end
		if (cmd.load_out) begin
			value_q <= is_lookup ? (f0_s5 + prody_s6[SB+FRAC_BITS-1:FRAC_BITS]) : '0;
		end
	end

	assign value = $signed(value_q);

endmodule

/* rtl/fbl_check.sv */
// port-level checker for the framed table lookup and its bind
module fbl_check (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    in_valid,
	input  logic                                    in_ready,
	input  logic [fbl_pkg::OP_BITS-1:0]             op,
	input  logic                                    out_valid,
	input  logic                                    out_ready,
	input  logic signed [fbl_pkg::SAMPLE_BITS-1:0]  value
);
	import fbl_pkg::*;

	logic [OP_BITS-1:0] last_op_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_op_q <= OP_NONE;
		end else if (in_valid && in_ready) begin
			last_op_q <= op;
		end
	end

	// only one word in flight
	a_one_word: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("word accepted while another is in flight");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(value))
		else $error("result dropped or changed while stalled");

	// a new result only appears at the end of busy time
	a_fresh_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!$past(out_valid) || $past(out_ready)) |-> !$past(in_ready))
		else $error("result appeared without a word in flight");

	a_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (!$past(out_valid) || $past(out_ready))
			&& (last_op_q == OP_WRITE || last_op_q == OP_NONE) |-> value == '0)
		else $error("non-lookup word gave a non-zero result");

endmodule

bind framed_table_bilinear_lookup fbl_check u_fbl_check (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.op        (op),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.value     (value)
);

/* tb/sv/testbench.sv */
// self-checking testbench for the framed table bilinear lookup
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import fbl_pkg::*;

	localparam int DEPTH        = DEF_MAX_WIDTH * DEF_MAX_FRAMES;
	localparam int ONE_Q16      = 1 << FRAC_BITS;
	localparam int WORD_TARGET  = 1250;
	localparam int HOLD_AFTER   = 150;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 16;
	localparam int CYCLE_LIMIT  = 400000;

	logic                          clk;
	logic                          arst_n;
	logic                          cfg_we;
	logic [CFG_IDX_BITS-1:0]       cfg_index;
	logic [CFG_DATA_BITS-1:0]      cfg_data;
	logic                          in_valid;
	logic                          in_ready;
	logic [OP_BITS-1:0]            op;
	logic [IDX_BITS-1:0]           entry_index;
	logic signed [SAMPLE_BITS-1:0] entry_value;
	logic [POS_BITS-1:0]           x_pos;
	logic [POS_BITS-1:0]           y_pos;
	logic                          out_valid;
	logic                          out_ready;
	logic signed [SAMPLE_BITS-1:0] value;

	framed_table_bilinear_lookup DUT (.*);

	// shadow copy of the table and registers
	logic signed [SAMPLE_BITS-1:0] samples [DEPTH];
	bit                            written [DEPTH];
	logic [WCFG_BITS-1:0]          width_reg;
	logic [HCFG_BITS-1:0]          frames_reg;
	int unsigned                   touched [$];
	logic signed [SAMPLE_BITS-1:0] pending_values [$];

	int words_sent;
	int results_taken;
	int mismatches;
	int cycles = 0;
	bit burst_mode;

	typedef enum bit {ROW_WORD, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t   kind;
		op_t         o;
		cfg_reg_t    sel;
		int unsigned idx;
		int          val;
		int unsigned x;
		int unsigned y;
		bit          typed;
		int          expv;
	} row_t;

	// kind, op, register, index, value or register data, x, y, typed, expected
	row_t directed_rows [] = '{
		'{ROW_WORD, OP_WRITE, REG_WIDTH, 0, 32767, 0, 0, 1, 0},
		'{ROW_WORD, OP_WRITE, REG_WIDTH, 1023, -32768, 0, 0, 1, 0},
		'{ROW_WORD, OP_LERP1, REG_WIDTH, 0, 0, 0, 0, 1, 32767},
		'{ROW_WORD, OP_LERP1, REG_WIDTH, 0, 0, 65536, 0, 1, -32768},
		'{ROW_WORD, OP_LERP1, REG_WIDTH, 0, 0, 131071, 0, 1, -32768},
		'{ROW_WORD, OP_LERP2, REG_WIDTH, 0, 0, 0, 131071, 1, 32767},
		'{ROW_WORD, OP_NONE, REG_WIDTH, 16383, -1, 131071, 131071, 1, 0},
		'{ROW_WORD, OP_WRITE, REG_WIDTH, 16383, 21845, 0, 0, 1, 0},
		'{ROW_WORD, OP_WRITE, REG_WIDTH, 1, 100, 0, 0, 1, 0},
		'{ROW_WORD, OP_LERP1, REG_WIDTH, 0, 0, 32, 0, 0, 0},
		'{ROW_REG, OP_NONE, REG_WIDTH, 0, 1, 0, 0, 0, 0},
		'{ROW_WORD, OP_LERP1, REG_WIDTH, 0, 0, 40000, 0, 1, 32767},
		'{ROW_REG, OP_NONE, REG_FRAMES, 0, 31, 0, 0, 0, 0},
		'{ROW_WORD, OP_WRITE, REG_WIDTH, 15, -7, 0, 0, 1, 0},
		'{ROW_WORD, OP_LERP2, REG_WIDTH, 0, 0, 5, 65536, 1, -7},
		'{ROW_WORD, OP_WRITE, REG_WIDTH, 14, 9, 0, 0, 1, 0},
		'{ROW_WORD, OP_LERP2, REG_WIDTH, 0, 0, 0, 65535, 0, 0},
		'{ROW_REG, OP_NONE, REG_WIDTH, 0, 0, 0, 0, 0, 0},
		'{ROW_WORD, OP_LERP1, REG_WIDTH, 0, 0, 65536, 0, 1, 32767},
		'{ROW_REG, OP_NONE, REG_WIDTH, 0, 2047, 0, 0, 0, 0},
		'{ROW_REG, OP_NONE, REG_FRAMES, 0, 2, 0, 0, 0, 0},
		'{ROW_WORD, OP_WRITE, REG_WIDTH, 2047, 1000, 0, 0, 1, 0},
		'{ROW_WORD, OP_WRITE, REG_WIDTH, 1024, -1000, 0, 0, 1, 0},
		'{ROW_WORD, OP_LERP2, REG_WIDTH, 0, 0, 65536, 65536, 1, 1000},
		'{ROW_WORD, OP_LERP2, REG_WIDTH, 0, 0, 0, 65536, 1, -1000},
		'{ROW_WORD, OP_LERP2, REG_WIDTH, 0, 0, 0, 32768, 0, 0},
		'{ROW_REG, OP_NONE, REG_FRAMES, 0, 0, 0, 0, 0, 0},
		'{ROW_WORD, OP_LERP2, REG_WIDTH, 0, 0, 65536, 100, 1, -32768}
	};

	function automatic int unsigned active_width();
		if (width_reg == 0) return 1;
		if (width_reg > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return width_reg;
	endfunction

	function automatic int unsigned active_frames();
		if (frames_reg == 0) return 1;
		if (frames_reg > DEF_MAX_FRAMES) return DEF_MAX_FRAMES;
		return frames_reg;
	endfunction

	// every table read is logged so that a lookup can be preceded by the writes it needs
	function automatic longint sample_at(int unsigned a);
		touched.push_back(a);
		return longint'(samples[a]);
	endfunction

	// product truncated toward minus infinity
	function automatic longint blend(longint a, longint b, longint frac);
		return a + (((b - a) * frac) >>> FRAC_BITS);
	endfunction

	function automatic longint along_frame(longint x, int unsigned frame);
		int unsigned w = active_width();
		int unsigned base = frame * w;
		longint pos;
		longint low;
		if (w == 1 || x == 0) return sample_at(base);
		if (x >= ONE_Q16) return sample_at(base + w - 1);
		pos = x * (w - 1);
		low = pos >>> FRAC_BITS;
		if (low + 1 >= w) low = w - 2;
		return blend(sample_at(base + low), sample_at(base + low + 1), pos & (ONE_Q16 - 1));
	endfunction

	function automatic longint across_frames(longint x, longint y);
		int unsigned h = active_frames();
		longint pos;
		longint low;
		longint f0;
		longint f1;
		if (h <= 1) return along_frame(x, 0);
		pos = y * (h - 1);
		low = pos >>> FRAC_BITS;
		// at or past the last frame only that frame is used
		if (low >= h - 1) return along_frame(x, h - 1);
		f0 = along_frame(x, low);
		f1 = along_frame(x, low + 1);
		return blend(f0, f1, pos & (ONE_Q16 - 1));
	endfunction

	function automatic logic signed [SAMPLE_BITS-1:0] interp_result(op_t o,
			logic [IDX_BITS-1:0] idx, logic signed [SAMPLE_BITS-1:0] val,
			logic [POS_BITS-1:0] x, logic [POS_BITS-1:0] y);
		longint r = 0;
		case (o)
			OP_WRITE: begin
				samples[idx] = val;
				written[idx] = 1'b1;
			end
			OP_LERP1: r = along_frame(x, 0);
			OP_LERP2: r = across_frames(x, y);
			default: r = 0;
		endcase
		return r[SAMPLE_BITS-1:0];
	endfunction

	function automatic logic [POS_BITS-1:0] pick_pos();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ONE_Q16;
			2: return $urandom_range(ONE_Q16 + 1, (1 << POS_BITS) - 1);
			3: return ONE_Q16 - 1;
			default: return $urandom_range(0, ONE_Q16);
		endcase
	endfunction

	task automatic send_word(op_t o, logic [IDX_BITS-1:0] idx,
			logic signed [SAMPLE_BITS-1:0] val, logic [POS_BITS-1:0] x,
			logic [POS_BITS-1:0] y, bit typed, logic signed [SAMPLE_BITS-1:0] typed_value);
		int gap = burst_mode ? 0 : $urandom_range(0, 12);
		logic signed [SAMPLE_BITS-1:0] predicted;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid    <= 1'b1;
		op          <= o;
		entry_index <= idx;
		entry_value <= val;
		x_pos       <= x;
		y_pos       <= y;
		do @(posedge clk); while (!in_ready);
		predicted = interp_result(o, idx, val, x, y);
		pending_values.push_back(typed ? typed_value : predicted);
		words_sent++;
	endtask

	// fill any entry the lookup would read before it has been written
	task automatic send_lookup(op_t o, logic [POS_BITS-1:0] x, logic [POS_BITS-1:0] y);
		int unsigned needed [$];
		touched.delete();
		void'(interp_result(o, '0, '0, x, y));
		needed = touched;
		foreach (needed[i])
			if (!written[needed[i]])
				send_word(OP_WRITE, needed[i], $urandom, pick_pos(), pick_pos(), 1'b0, '0);
		send_word(o, $urandom, $urandom, x, y, 1'b0, '0);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_values.size() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t sel, logic [CFG_DATA_BITS-1:0] d);
		cfg_we    <= 1'b1;
		cfg_index <= sel;
		cfg_data  <= d;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (sel == REG_WIDTH)
			width_reg = d[WCFG_BITS-1:0];
		else
			frames_reg = d[HCFG_BITS-1:0];
	endtask

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// result side: random stalls plus one long hold-off to back the block up
	initial begin
		int stall;
		bit held;
		logic signed [SAMPLE_BITS-1:0] wanted;
		held = 1'b0;
		out_ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (!held && results_taken == HOLD_AFTER) begin
				held = 1'b1;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end
			stall = burst_mode ? 0 : $urandom_range(0, 12);
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (pending_values.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected word out: value %0d", value);
			end else begin
				wanted = pending_values.pop_front();
				if (value !== wanted) begin
					mismatches++;
					if (mismatches <= 10)
						$display("word %0d: expected %0d, got %0d", results_taken, wanted, value);
				end
			end
			results_taken++;
		end
	end

	initial begin
		int phase_end;
		int kind;
		int unsigned idx;
		logic [CFG_DATA_BITS-1:0] d;
		arst_n      = 1'b0;
		cfg_we      = 1'b0;
		cfg_index   = REG_WIDTH;
		cfg_data    = '0;
		in_valid    = 1'b0;
		op          = OP_WRITE;
		entry_index = '0;
		entry_value = '0;
		x_pos       = '0;
		y_pos       = '0;
		words_sent    = 0;
		results_taken = 0;
		mismatches    = 0;
		burst_mode    = 1'b0;
		width_reg     = WIDTH_RESET;
		frames_reg    = FRAMES_RESET;
		foreach (samples[i]) begin
			samples[i] = '0;
			written[i] = 1'b0;
		end
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_REG) begin
				settle();
				write_reg(directed_rows[i].sel, directed_rows[i].val);
			end else begin
				send_word(directed_rows[i].o, directed_rows[i].idx, directed_rows[i].val,
					directed_rows[i].x, directed_rows[i].y, directed_rows[i].typed,
					directed_rows[i].expv);
			end
		end

		while (words_sent < WORD_TARGET) begin
			settle();
			case ($urandom_range(0, 7))
				0: d = 1;
				1: d = 2;
				2: d = $urandom_range(3, 16);
				3: d = $urandom_range(17, DEF_MAX_WIDTH);
				4: d = DEF_MAX_WIDTH;
				5: d = 0;
				6: d = $urandom_range(DEF_MAX_WIDTH + 1, (1 << WCFG_BITS) - 1);
				default: d = $urandom_range(2, 8);
			endcase
			write_reg(REG_WIDTH, d);
			// upper data bits are don't-care for the frame count
			d = $urandom;
			case ($urandom_range(0, 5))
				0: d[HCFG_BITS-1:0] = 1;
				1: d[HCFG_BITS-1:0] = DEF_MAX_FRAMES;
				2: d[HCFG_BITS-1:0] = $urandom_range(2, DEF_MAX_FRAMES - 1);
				3: d[HCFG_BITS-1:0] = 0;
				4: d[HCFG_BITS-1:0] = $urandom_range(DEF_MAX_FRAMES + 1, (1 << HCFG_BITS) - 1);
				default: d[HCFG_BITS-1:0] = 2;
			endcase
			write_reg(REG_FRAMES, d);
			burst_mode = ($urandom_range(0, 3) == 0);
			phase_end = words_sent + $urandom_range(60, 160);
			while (words_sent < phase_end && words_sent < WORD_TARGET) begin
				kind = $urandom_range(0, 99);
				if (kind < 22) begin
					if ($urandom_range(0, 7) == 0)
						idx = $urandom_range(0, DEPTH - 1);
					else
						idx = $urandom_range(0, active_frames() - 1) * active_width()
							+ $urandom_range(0, active_width() - 1);
					send_word(OP_WRITE, idx, $urandom, pick_pos(), pick_pos(), 1'b0, '0);
				end else if (kind < 27) begin
					send_word(OP_NONE, $urandom, $urandom, pick_pos(), pick_pos(), 1'b0, '0);
				end else if (kind < 55) begin
					send_lookup(OP_LERP1, pick_pos(), pick_pos());
				end else begin
					send_lookup(OP_LERP2, pick_pos(), pick_pos());
				end
			end
		end

		settle();
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

/* files.f */
rtl/fbl_pkg.sv
rtl/fbl_ctrl.sv
rtl/fbl_dpath.sv
rtl/framed_table_bilinear_lookup.sv
rtl/fbl_check.sv
tb/sv/testbench.sv
